@@ rtl/hps_pkg.sv @@
// Package for the Hermite path sampler: payload structs, lane control types,
// fixed widths and the cubic basis function. No dependencies.
package hps_pkg;

   localparam int LANES = 3;
   localparam int N_W   = 5;    // segment sample count, up to 31
   localparam int D2_W  = 49;   // square of one 25-bit coordinate difference
   localparam int SQ_W  = 50;   // sum of three squares

   typedef struct packed {
      logic signed [23:0] waypoint_x;
      logic signed [23:0] waypoint_y;
      logic signed [23:0] waypoint_z;
      logic               final_waypoint;
   } hps_req_type;

   typedef struct packed {
      logic signed [23:0] sample_x;
      logic signed [23:0] sample_y;
      logic signed [23:0] sample_z;
      logic               final_sample;
   } hps_rsp_type;

   typedef struct packed {
      logic signed [23:0] p0;
      logic signed [23:0] p1;
      logic signed [26:0] m0;
      logic signed [26:0] m1;
   } hps_seg_type;

   typedef struct packed {
      logic signed [15:0] h00;
      logic signed [15:0] h10;
      logic signed [15:0] h01;
      logic signed [15:0] h11;
      logic        [15:0] n3;
   } hps_basis_type;

   typedef struct packed {
      logic load;
      logic start;
   } hps_lane_ctrl_type;

   function automatic logic [14:0] cube(input logic [N_W-1:0] v);
      logic [14:0] w;
      w = {10'd0, v};
      return 15'(w * w * w);
   endfunction

   function automatic logic [9:0] sqr(input logic [N_W-1:0] v);
      logic [9:0] w;
      w = {5'd0, v};
      return 10'(w * w);
   endfunction

   // Basis weights scaled by n^3 for sample k of n.
   function automatic hps_basis_type basis(input logic [N_W-1:0] k,
                                           input logic [N_W-1:0] n);
      logic signed [18:0] k3, n3, k2n, kn2;
      hps_basis_type b;
      k3  = $signed({4'd0, cube(k)});
      n3  = $signed({4'd0, cube(n)});
      k2n = $signed({4'd0, 15'({5'd0, sqr(k)} * {10'd0, n})});
      kn2 = $signed({4'd0, 15'({10'd0, k} * {5'd0, sqr(n)})});
      b.h00 = 16'(2 * k3 - 3 * k2n + n3);
      b.h10 = 16'(k3 - 2 * k2n + kn2);
      b.h01 = 16'(3 * k2n - 2 * k3);
      b.h11 = 16'(k3 - k2n);
      b.n3  = 16'(n3);
      return b;
   endfunction

endpackage

@@ rtl/hps_lane.sv @@
// One coordinate lane: chord-difference square, Hermite multiply-accumulate
// and restoring divide by 2n^3. Depends on hps_pkg.
module hps_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  hps_pkg::hps_lane_ctrl_type   ctrl,
   input  hps_pkg::hps_seg_type         seg,
   input  hps_pkg::hps_basis_type       basis_w,
   output logic [hps_pkg::D2_W-1:0]     d2,
   output logic                         done,
   output logic signed [23:0]           res
);
   import hps_pkg::*;

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_MAC  = 2'd1;
   localparam logic [1:0] L_DIV  = 2'd2;
   localparam logic [1:0] L_FIN  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [4:0]          step_ff, step_in;
   hps_seg_type         seg_ff;
   hps_basis_type       bas_ff;
   logic signed [45:0]  acc_ff, acc_in;
   logic [16:0]         rem_ff, rem_in;
   logic [27:0]         quo_ff, quo_in;
   logic [15:0]         dvs_ff;
   logic [D2_W-1:0]     d2_ff;
   logic                done_ff, done_in;
   logic signed [23:0]  res_ff, res_in;

   logic signed [24:0]  diff;
   logic signed [49:0]  dsq;
   logic signed [15:0]  coef;
   logic signed [26:0]  opnd;
   logic signed [42:0]  prod;
   logic signed [45:0]  dvd;
   logic [15:0]         dvs;
   logic [17:0]         trial;
   logic                ge;
   logic signed [28:0]  q;

   assign diff = $signed({seg_ff.p1[23], seg_ff.p1}) - $signed({seg_ff.p0[23], seg_ff.p0});
   assign dsq  = diff * diff;

   always_comb begin
      case (step_ff[1:0])
         2'd0:    begin coef = bas_ff.h00; opnd = {{2{seg_ff.p0[23]}}, seg_ff.p0, 1'b0}; end
         2'd1:    begin coef = bas_ff.h10; opnd = seg_ff.m0; end
         2'd2:    begin coef = bas_ff.h01; opnd = {{2{seg_ff.p1[23]}}, seg_ff.p1, 1'b0}; end
         default: begin coef = bas_ff.h11; opnd = seg_ff.m1; end
      endcase
   end
   assign prod = coef * opnd;

   // Bias by 2^27 divisors so the floor divide runs on a positive dividend.
   assign dvs = {bas_ff.n3[14:0], 1'b0};
   assign dvd = acc_ff + $signed({30'd0, bas_ff.n3}) + $signed({3'b000, dvs, 27'd0});

   assign trial = {rem_ff, quo_ff[27]};
   assign ge    = trial >= {2'b00, dvs_ff};
   assign q     = $signed({1'b0, quo_ff}) - $signed(29'h0800_0000);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      done_in  = done_ff;
      res_in   = res_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (ctrl.start) begin
               state_in = L_MAC;
               step_in  = '0;
               acc_in   = '0;
               done_in  = 1'b0;
            end
         end
         L_MAC: begin
            if (step_ff == 5'd4) begin
               rem_in   = dvd[44:28];
               quo_in   = dvd[27:0];
               step_in  = '0;
               state_in = L_DIV;
            end else begin
               acc_in  = acc_ff + {{3{prod[42]}}, prod};
               step_in = step_ff + 5'd1;
            end
         end
         L_DIV: begin
            rem_in  = ge ? 17'(trial - {2'b00, dvs_ff}) : trial[16:0];
            quo_in  = {quo_ff[26:0], ge};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd27) state_in = L_FIN;
         end
         L_FIN: begin
            if (q > 29'sd8388607)       res_in = 24'sh7FFFFF;
            else if (q < -29'sd8388608) res_in = 24'sh800000;
            else                        res_in = q[23:0];
            done_in  = 1'b1;
            state_in = L_IDLE;
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
      d2_ff   <= dsq[D2_W-1:0];
      if (state_ff == L_MAC && step_ff == 5'd4) dvs_ff <= dvs;
      if (ctrl.load) seg_ff <= seg;
      if (ctrl.start) bas_ff <= basis_w;
   end

   assign d2   = d2_ff;
   assign done = done_ff;
   assign res  = res_ff;

endmodule

@@ rtl/hps_merge.sv @@
// Merge stage: sums the lane chord squares and packs lane results into a
// sample. Depends on hps_pkg.
module hps_merge (
   input  logic [hps_pkg::D2_W-1:0]  lane_d2  [hps_pkg::LANES],
   input  logic signed [23:0]        lane_res [hps_pkg::LANES],
   input  logic                      fin,
   output logic [hps_pkg::SQ_W-1:0]  sq,
   output hps_pkg::hps_rsp_type      sample
);
   import hps_pkg::*;

   assign sq = {1'b0, lane_d2[0]} + {1'b0, lane_d2[1]} + {1'b0, lane_d2[2]};

   always_comb begin
      sample.sample_x     = lane_res[0];
      sample.sample_y     = lane_res[1];
      sample.sample_z     = lane_res[2];
      sample.final_sample = fin;
   end

endmodule

@@ rtl/hermite_path_sampler.sv @@
// Hermite path sampler: Catmull-Rom resampling of a 3-D waypoint stream.
// Each segment: sample count setup, then each sample runs the 4-step
// multiply-accumulate and 28-step divide per lane.
// Throughput: one request at a time; a waypoint can give up to two segments.
// Next request accepted on return to idle.
// Reset: synchronous, active high; clears path state, spacing returns to 64.
module hermite_path_sampler #(
   parameter int MAX_SAMPLES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hps_pkg::hps_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hps_pkg::hps_rsp_type  rsp_data,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data
);
   import hps_pkg::*;

   localparam logic [N_W-1:0] MAX_N = N_W'(MAX_SAMPLES);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_FIRST = 4'd2;
   localparam logic [3:0] S_LOAD  = 4'd3;
   localparam logic [3:0] S_SQ    = 4'd4;
   localparam logic [3:0] S_SUM   = 4'd5;
   localparam logic [3:0] S_COUNT = 4'd6;
   localparam logic [3:0] S_BASIS = 4'd7;
   localparam logic [3:0] S_START = 4'd8;
   localparam logic [3:0] S_WAIT  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   // Segment kinds: interior b->c, two-point path c->w, closing c->w.
   localparam logic [1:0] SEG_MID   = 2'd0;
   localparam logic [1:0] SEG_FIRST = 2'd1;
   localparam logic [1:0] SEG_LAST  = 2'd2;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          seen_ff, seen_in;
   logic [1:0]          kind_ff, kind_in;
   logic                fin_ff;
   logic [N_W-1:0]      n_ff, n_in, k_ff, k_in;
   logic [20:0]         r_ff, r_in;
   logic [SQ_W-1:0]     sq_ff;
   logic [15:0]         spacing_ff;
   hps_basis_type       basis_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   hps_rsp_type         rsp_ff, rsp_in;

   // Waypoint history: a oldest, c newest; w is the request in flight.
   logic signed [23:0]  a_ff [LANES];
   logic signed [23:0]  b_ff [LANES];
   logic signed [23:0]  c_ff [LANES];
   logic signed [23:0]  w_ff [LANES];

   logic                accept, out_free, out_load, push;
   logic [41:0]         rr;
   hps_lane_ctrl_type   lane_ctrl;
   hps_seg_type         lane_seg  [LANES];
   logic [D2_W-1:0]     lane_d2   [LANES];
   logic                lane_done [LANES];
   logic signed [23:0]  lane_res  [LANES];
   logic [SQ_W-1:0]     sq;
   hps_rsp_type         merged;
   logic                last_k;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rr        = r_ff * r_ff;
   assign last_k    = (k_ff == n_ff);

   assign lane_ctrl.load  = (state_ff == S_LOAD);
   assign lane_ctrl.start = (state_ff == S_START);

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic signed [24:0] d_cb, d_wb, d_wc, d_ca;
      assign d_cb = $signed({c_ff[i][23], c_ff[i]}) - $signed({b_ff[i][23], b_ff[i]});
      assign d_wb = $signed({w_ff[i][23], w_ff[i]}) - $signed({b_ff[i][23], b_ff[i]});
      assign d_wc = $signed({w_ff[i][23], w_ff[i]}) - $signed({c_ff[i][23], c_ff[i]});
      assign d_ca = $signed({c_ff[i][23], c_ff[i]}) - $signed({a_ff[i][23], a_ff[i]});

      // Pick segment end points and tangents (tangents scaled by two).
      always_comb begin
         case (kind_ff)
            SEG_MID: begin
               lane_seg[i].p0 = b_ff[i];
               lane_seg[i].p1 = c_ff[i];
               lane_seg[i].m0 = (seen_ff == 2'd3) ? {{2{d_ca[24]}}, d_ca}
                                                  : {d_cb[24], d_cb, 1'b0};
               lane_seg[i].m1 = {{2{d_wb[24]}}, d_wb};
            end
            SEG_FIRST: begin
               lane_seg[i].p0 = c_ff[i];
               lane_seg[i].p1 = w_ff[i];
               lane_seg[i].m0 = {d_wc[24], d_wc, 1'b0};
               lane_seg[i].m1 = {d_wc[24], d_wc, 1'b0};
            end
            default: begin
               lane_seg[i].p0 = c_ff[i];
               lane_seg[i].p1 = w_ff[i];
               lane_seg[i].m0 = {{2{d_wb[24]}}, d_wb};
               lane_seg[i].m1 = {d_wc[24], d_wc, 1'b0};
            end
         endcase
      end

      hps_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (lane_ctrl),
         .seg     (lane_seg[i]),
         .basis_w (basis_ff),
         .d2      (lane_d2[i]),
         .done    (lane_done[i]),
         .res     (lane_res[i])
      );
   end

   hps_merge u_merge (
      .lane_d2  (lane_d2),
      .lane_res (lane_res),
      .fin      (fin_ff && (kind_ff != SEG_MID) && last_k),
      .sq       (sq),
      .sample   (merged)
   );

   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      kind_in      = kind_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      push         = 1'b0;
      out_load     = 1'b0;
      rsp_in       = merged;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DISP;
         end
         S_DISP: begin
            unique case (seen_ff)
               2'd0: begin
                  // Single waypoint path: drop it when final.
                  if (!fin_ff) begin
                     push    = 1'b1;
                     seen_in = 2'd1;
                  end
                  state_in = S_IDLE;
               end
               2'd1: state_in = S_FIRST;
               default: begin
                  kind_in  = SEG_MID;
                  state_in = S_LOAD;
               end
            endcase
         end
         S_FIRST: begin
            // Emit the path's first waypoint as a sample.
            rsp_in.sample_x     = c_ff[0];
            rsp_in.sample_y     = c_ff[1];
            rsp_in.sample_z     = c_ff[2];
            rsp_in.final_sample = 1'b0;
            if (out_free) begin
               out_load = 1'b1;
               if (fin_ff) begin
                  kind_in  = SEG_FIRST;
                  state_in = S_LOAD;
               end else begin
                  push     = 1'b1;
                  seen_in  = 2'd2;
                  state_in = S_IDLE;
               end
            end
         end
         S_LOAD: state_in = S_SQ;
         S_SQ:   state_in = S_SUM;
         S_SUM: begin
            n_in     = N_W'(2);
            r_in     = {4'd0, spacing_ff, 1'b0};
            state_in = S_COUNT;
         end
         S_COUNT: begin
            // Advance n until (n * spacing)^2 covers the chord or n saturates.
            if (n_ff < MAX_N && {8'd0, rr} < sq_ff) begin
               n_in = n_ff + N_W'(1);
               r_in = r_ff + {5'd0, spacing_ff};
            end else begin
               k_in     = N_W'(1);
               state_in = S_BASIS;
            end
         end
         S_BASIS: state_in = S_START;
         S_START: state_in = S_WAIT;
         S_WAIT: begin
            if (lane_done[0] && lane_done[1] && lane_done[2]) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (!last_k) begin
                  k_in     = k_ff + N_W'(1);
                  state_in = S_BASIS;
               end else if (kind_ff == SEG_MID) begin
                  if (fin_ff) begin
                     kind_in  = SEG_LAST;
                     state_in = S_LOAD;
                  end else begin
                     push     = 1'b1;
                     seen_in  = 2'd3;
                     state_in = S_IDLE;
                  end
               end else begin
                  seen_in  = 2'd0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seen_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
         spacing_ff   <= 16'd64;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) spacing_ff <= csr_wr_data;
      end
      kind_ff <= kind_in;
      n_ff    <= n_in;
      k_ff    <= k_in;
      r_ff    <= r_in;
      if (state_ff == S_SUM) sq_ff <= sq;
      if (state_ff == S_BASIS) basis_ff <= basis(k_ff, n_ff);
      if (out_load) rsp_ff <= rsp_in;
      if (accept) begin
         fin_ff  <= req_data.final_waypoint;
         w_ff[0] <= req_data.waypoint_x;
         w_ff[1] <= req_data.waypoint_y;
         w_ff[2] <= req_data.waypoint_z;
      end
      if (push) begin
         for (int i = 0; i < LANES; i++) begin
            a_ff[i] <= b_ff[i];
            b_ff[i] <= c_ff[i];
            c_ff[i] <= w_ff[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BASIS) |-> (n_ff >= N_W'(2) && n_ff <= MAX_N))
      else $error("sample count out of range");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (k_ff >= N_W'(1) && k_ff <= n_ff))
      else $error("sample index out of range");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending sample overwritten");

endmodule

@@ verif/hps_checker.sv @@
`timescale 1ns / 100ps
// Checker for the Hermite path sampler: watches the request, response and
// register ports, predicts the curve samples and compares. Depends on hps_pkg.
module hps_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  hps_pkg::hps_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  hps_pkg::hps_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   output int                   errors,
   output int                   samples_owed
);
   import hps_pkg::*;

   localparam int MAX_SAMPLES = 16;

   typedef longint coord_vec_type [3];

   hps_rsp_type    sample_queue [$];
   coord_vec_type  path_hist [3];   // oldest first
   int             path_len;
   longint         spacing;

   function automatic longint sat24(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic void push_sample(input coord_vec_type v, input bit fin);
      hps_rsp_type s;
      s.sample_x     = 24'(sat24(v[0]));
      s.sample_y     = 24'(sat24(v[1]));
      s.sample_z     = 24'(sat24(v[2]));
      s.final_sample = fin;
      sample_queue.insert(sample_queue.size(), s);
   endfunction

   function automatic longint floor_div(input longint num, input longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      return q;
   endfunction

   // Sample one segment at t = k/n, n from the chord length and spacing.
   function automatic void sample_segment(input coord_vec_type p0, input coord_vec_type p1,
                                          input coord_vec_type m0, input coord_vec_type m1,
                                          input bit fin);
      longint        chord_sq, d, r, n, n3, k2, k3, h00, h10, h01, h11, num;
      coord_vec_type v;
      chord_sq = 0;
      for (int i = 0; i < 3; i++) begin
         d = p1[i] - p0[i];
         chord_sq += d * d;
      end
      for (n = 2; n < MAX_SAMPLES; n++) begin
         r = n * spacing;
         if (r * r >= chord_sq) break;
      end
      n3 = n * n * n;
      for (longint k = 1; k <= n; k++) begin
         k2  = k * k;
         k3  = k2 * k;
         h00 = 2 * k3 - 3 * k2 * n + n3;
         h10 = k3 - 2 * k2 * n + k * n * n;
         h01 = 3 * k2 * n - 2 * k3;
         h11 = k3 - k2 * n;
         for (int i = 0; i < 3; i++) begin
            num  = h00 * 2 * p0[i] + h10 * m0[i] + h01 * 2 * p1[i] + h11 * m1[i];
            v[i] = floor_div(num + n3, 2 * n3);
         end
         push_sample(v, fin && k == n);
      end
   endfunction

   function automatic void predict_samples(input hps_req_type w_in);
      coord_vec_type w, a, b, c, m0, m1;
      bit            fin;
      fin  = w_in.final_waypoint;
      w[0] = longint'(w_in.waypoint_x);
      w[1] = longint'(w_in.waypoint_y);
      w[2] = longint'(w_in.waypoint_z);
      a = path_hist[0];
      b = path_hist[1];
      c = path_hist[2];
      if (path_len == 0) begin
         if (!fin) begin
            path_hist[2] = w;
            path_len     = 1;
         end
      end else if (path_len == 1) begin
         push_sample(c, 1'b0);
         if (fin) begin
            for (int i = 0; i < 3; i++) begin
               m0[i] = 2 * (w[i] - c[i]);
               m1[i] = m0[i];
            end
            sample_segment(c, w, m0, m1, 1'b1);
            path_len = 0;
         end else begin
            path_hist[1] = c;
            path_hist[2] = w;
            path_len     = 2;
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            m0[i] = (path_len == 3) ? (c[i] - a[i]) : 2 * (c[i] - b[i]);
            m1[i] = w[i] - b[i];
         end
         sample_segment(b, c, m0, m1, 1'b0);
         if (fin) begin
            for (int i = 0; i < 3; i++) begin
               m0[i] = w[i] - b[i];
               m1[i] = 2 * (w[i] - c[i]);
            end
            sample_segment(c, w, m0, m1, 1'b1);
            path_len = 0;
         end else begin
            path_hist[0] = b;
            path_hist[1] = c;
            path_hist[2] = w;
            path_len     = 3;
         end
      end
   endfunction

   always @(posedge clock) begin
      hps_rsp_type want;
      if (reset) begin
         sample_queue.delete();
         path_len = 0;
         spacing  = 64;
         errors   = 0;
      end else begin
         if (csr_wr_en) spacing = csr_wr_data;
         // predict first so a same-edge response still finds its entry
         if (req_valid && req_ready) predict_samples(req_data);
         if (rsp_valid && rsp_ready) begin
            if (sample_queue.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected sample x=%0d y=%0d z=%0d fin=%0b", rsp_data.sample_x,
                           rsp_data.sample_y, rsp_data.sample_z, rsp_data.final_sample);
            end else begin
               want = sample_queue.pop_front();
               if (rsp_data.sample_x !== want.sample_x || rsp_data.sample_y !== want.sample_y
                   || rsp_data.sample_z !== want.sample_z
                   || rsp_data.final_sample !== want.final_sample) begin
                  errors++;
                  if (errors <= 10)
                     $display("sample mismatch: exp %0d %0d %0d fin=%0b, got %0d %0d %0d fin=%0b",
                              want.sample_x, want.sample_y, want.sample_z, want.final_sample,
                              rsp_data.sample_x, rsp_data.sample_y, rsp_data.sample_z,
                              rsp_data.final_sample);
               end
            end
         end
      end
      samples_owed = sample_queue.size();
   end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Top of the Hermite path sampler testbench: clock, reset, waypoint and
// register stimulus, response stalls and verdict. Depends on hps_pkg, hps_checker.
module testbench;
   import hps_pkg::*;

   localparam int IDLE_LIMIT = 20000;  // cycles without any handshake
   localparam int DRAIN_WAIT = 120;    // covers one sample plus setup

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   hps_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   hps_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   int          errors;
   int          samples_owed;
   int          idle_cycles = 0;
   bit          long_hold = 1'b0;   // ask the response side for a long stall
   bit          quiet = 1'b0;       // no idling on either side

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   hermite_path_sampler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hps_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .errors       (errors),
      .samples_owed (samples_owed)
   );

   // Watchdog: end the run if no request or sample moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Response side: random stall bursts, one long hold on request.
   always begin
      @(negedge clock);
      if (long_hold) begin
         rsp_ready <= 1'b0;
         repeat (400) @(negedge clock);
         long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 9) - 1) @(negedge clock);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one waypoint request and hold it until accepted.
   task automatic send_waypoint(input logic [23:0] x, input logic [23:0] y,
                                input logic [23:0] z, input bit fin);
      // the block is never ready right after an accept, so step past the drop
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{waypoint_x: x, waypoint_y: y, waypoint_z: z, final_waypoint: fin};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait out every owed sample, then let the block settle back to idle.
   task automatic drain_samples();
      while (samples_owed != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_spacing(input logic [15:0] value);
      drain_samples();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Next coordinate: mostly a modest step from the last one, sometimes anywhere.
   function automatic logic [23:0] next_coord(input logic [23:0] last, input int reach);
      if ($urandom_range(0, 9) == 0) return 24'($urandom);
      return 24'($signed(last) + $signed($urandom_range(0, 2 * reach)) - reach);
   endfunction

   // Random path of 1..6 waypoints, the last one usually marked final.
   task automatic send_path(input int reach, inout int sent);
      int          len;
      logic [23:0] x, y, z;
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
      x = 24'($urandom);
      y = 24'($urandom);
      z = 24'($urandom);
      for (int i = 0; i < len; i++) begin
         // a few broken paths: drop the final flag off the end
         send_waypoint(x, y, z, (i == len - 1) && ($urandom_range(0, 15) != 0));
         sent++;
         x = next_coord(x, reach);
         y = next_coord(y, reach);
         z = next_coord(z, reach);
      end
   endtask

   initial begin
      localparam logic [23:0] PMAX = 24'h7FFFFF;
      localparam logic [23:0] PMIN = 24'h800000;
      int sent;
      int reach;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: single waypoint path gives nothing.
      send_waypoint(24'd100, 24'd200, 24'd300, 1'b1);
      // Extreme chord, n saturates; two-point path at reset spacing.
      send_waypoint(PMIN, PMIN, PMIN, 1'b0);
      send_waypoint(PMAX, PMAX, PMAX, 1'b1);
      // Overshoot: zig-zag between extremes saturates the curve.
      send_waypoint(PMAX, PMIN, PMAX, 1'b0);
      send_waypoint(PMIN, PMAX, PMIN, 1'b0);
      send_waypoint(PMAX, PMIN, PMAX, 1'b0);
      send_waypoint(PMIN, PMAX, PMIN, 1'b1);
      // Zero-length chord.
      send_waypoint(24'd5, 24'd5, 24'd5, 1'b0);
      send_waypoint(24'd5, 24'd5, 24'd5, 1'b1);

      // Zero spacing: n is 2 on a zero chord, the maximum otherwise.
      write_spacing(16'd0);
      send_waypoint(-24'sd7, 24'd0, 24'd0, 1'b0);
      send_waypoint(-24'sd7, 24'd0, 24'd0, 1'b0);
      send_waypoint(24'd9, 24'd3, -24'sd1, 1'b1);

      // Smallest and largest spacing, longer path through the steady state.
      write_spacing(16'd1);
      send_waypoint(24'd0, 24'd0, 24'd0, 1'b0);
      send_waypoint(24'd3, 24'd0, 24'd0, 1'b0);
      send_waypoint(24'd3, 24'd4, 24'd0, 1'b0);
      send_waypoint(24'd0, 24'd4, 24'd2, 1'b0);
      send_waypoint(24'd1, 24'd1, 24'd1, 1'b1);
      write_spacing(16'hFFFF);
      send_waypoint(24'd1000, -24'sd2000, 24'd3000, 1'b0);
      send_waypoint(24'd900000, 24'd5, -24'sd70000, 1'b0);
      send_waypoint(PMIN, PMAX, 24'd0, 1'b1);

      // Random phases, each at its own spacing; long stall in the second.
      sent = 0;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0:       write_spacing(16'd64);
            3:       write_spacing(16'($urandom_range(1, 65535)));
            default: write_spacing(16'($urandom_range(1, 2000)));
         endcase
         if (phase == 6) quiet = 1'b1;
         reach = (phase == 3) ? 8000000 : $urandom_range(100, 20000);
         if (phase == 1) long_hold = 1'b1;
         for (int start = sent; sent - start < 38; ) begin
            send_path(reach, sent);
            // once in a while hold new requests until the block is empty
            if ($urandom_range(0, 9) == 0)
               while (samples_owed != 0) @(negedge clock);
         end
      end

      drain_samples();
      if (errors == 0 && samples_owed == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
